[src/sitar_pkg.sv]
// ----------------------------------------------------------------------------
// sitar_pkg: shared types and constants for the integer-to-text record block
// Holds the text entry passed from converter to emitter, queue status,
// converter states, character codes and register decode constants.
// ----------------------------------------------------------------------------
`default_nettype none

package sitar_pkg;

  // Most decimal digits of a 32-bit magnitude
  localparam int unsigned DigitMax = 10;

  // Exact divide-by-ten for 32-bit operands: q = (x * Recip10) >> RecipShift
  localparam logic [31:0] Recip10    = 32'hCCCC_CCCD;
  localparam int unsigned RecipShift = 35;

  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChLf    = 8'h0A;

  localparam logic [4:0] LenMin   = 5'd2;
  localparam logic [4:0] LenMax   = 5'd23;
  localparam logic [4:0] LenReset = 5'd13;

  // Register index, taken from address bit 2
  localparam logic RegRecordLength = 1'b0;

  // One converted value: sign and digits, least significant digit first
  typedef struct packed {
    logic                        neg;
    logic [3:0]                  ndig;
    logic [DigitMax-1:0][3:0]    dig;
  } sitar_text_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sitar_qstat_t;

  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } sitar_front_e;

endpackage

`default_nettype wire

[src/signed_int_to_ascii_record.sv]
// ----------------------------------------------------------------------------
// signed_int_to_ascii_record: signed integer to fixed-length text record
// Converts a signed 32-bit value to decimal ASCII and emits a record of
// record_length bytes, one byte per cycle, ending in CR LF.
// ----------------------------------------------------------------------------
// Pulse start with a value while busy is low. The block answers with a
// record of record_length bytes (clamped to 2..23), one word per cycle on
// out_byte_o with strobe_o high, back to back: the decimal text (leading
// '-' for negatives, most significant digit first, cut to record_length-2
// characters), zero pad bytes, CR, then LF with last_o high. There is no
// backpressure on the result side; the receiver must take every word in
// the cycle it appears. The converter splits the magnitude into decimal
// digits (1 to 10), then hands the text to the queue, waiting while the
// queue is full; busy stays high until that hand-off. A two-entry queue
// lets the next value be converted while the previous record is still
// going out. The first byte of a record is registered in the emitter once
// its text is at the head of the queue. Sustained, the slower of converter
// and emitter sets the rate; the emitter, at one byte per cycle, sets it
// for any record that takes longer to send than its value to convert.
// record_length is written over the APB port at byte address 0 and is
// only to be changed while no record is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_int_to_ascii_record #(
  parameter int unsigned DIGIT_SLOTS = 21
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // command side
  input  logic        start,
  output logic        busy,
  input  logic [31:0] value_i,
  // result side
  output logic [7:0]  out_byte_o,
  output logic        last_o,
  output logic        strobe_o,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import sitar_pkg::*;

  logic [4:0]   record_length_q;
  logic         cfg_wr;
  logic         push, pop;
  sitar_qstat_t qstat;
  sitar_text_t  front_text, head_text;

  // APB: zero-wait; write completes in the access phase
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      record_length_q <= LenReset;
    end else if (cfg_wr && (paddr[2] == RegRecordLength)) begin
      record_length_q <= pwdata[4:0];
    end
  end

  // Read back the register; unmapped addresses read as zero
  assign prdata = (paddr[2] == RegRecordLength) ? {27'd0, record_length_q} : 32'd0;

  // Converter: accept a value, split it into digits
  sitar_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .value_i (value_i),
    .qstat_i (qstat),
    .busy_o  (busy),
    .push_o  (push),
    .text_o  (front_text)
  );

  // Hold up to two converted values between converter and emitter
  sitar_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (front_text),
    .pop_i       (pop),
    .stat_o      (qstat),
    .head_o      (head_text)
  );

  // Emitter: walk the head entry out as a record, drop it on LF
  sitar_back #(
    .DIGIT_SLOTS (DIGIT_SLOTS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .record_length_i (record_length_q),
    .qstat_i         (qstat),
    .head_i          (head_text),
    .pop_o           (pop),
    .out_byte_o      (out_byte_o),
    .last_o          (last_o),
    .strobe_o        (strobe_o)
  );

endmodule

`default_nettype wire

[src/sitar_front.sv]
// ----------------------------------------------------------------------------
// sitar_front: value converter
// Takes a value, splits its magnitude into decimal digits one per cycle
// with a reciprocal multiply, and hands the finished text to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sitar_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic [31:0]            value_i,
  input  sitar_pkg::sitar_qstat_t qstat_i,
  output logic                   busy_o,
  output logic                   push_o,
  output sitar_pkg::sitar_text_t text_o
);
  import sitar_pkg::*;

  sitar_front_e             state_q, state_d;
  logic [31:0]              mag_q;
  logic                     neg_q;
  logic [3:0]               ndig_q;
  logic [DigitMax-1:0][3:0] dig_q;
  logic                     load, step;
  logic [63:0]              prod;
  logic [31:0]              quot, rem;

  assign prod = 64'(mag_q) * 64'(Recip10);
  assign quot = 32'(prod >> RecipShift);
  assign rem  = mag_q - ((quot << 3) + (quot << 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= FR_IDLE;
      ndig_q  <= '0;
    end else begin
      state_q <= state_d;
      if (load) begin
        ndig_q <= '0;
      end else if (step) begin
        ndig_q <= ndig_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q <= value_i[31];
      mag_q <= value_i[31] ? (32'd0 - value_i) : value_i;
    end else if (step) begin
      dig_q[ndig_q] <= rem[3:0];
      mag_q         <= quot;
    end
  end

  always_comb begin
    state_d = state_q;
    busy_o  = (state_q != FR_IDLE);
    push_o  = 1'b0;
    load    = 1'b0;
    step    = 1'b0;
    unique case (state_q)
      FR_IDLE: begin
        if (start_i) begin
          load    = 1'b1;
          state_d = FR_DIV;
        end
      end
      FR_DIV: begin
        step = 1'b1;
        if (quot == 32'd0) begin
          state_d = FR_PUSH;
        end
      end
      FR_PUSH: begin
        if (!qstat_i.full) begin
          push_o  = 1'b1;
          state_d = FR_IDLE;
        end
      end
      default: state_d = FR_IDLE;
    endcase
  end

  assign text_o = '{neg: neg_q, ndig: ndig_q, dig: dig_q};

  a_digit_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == FR_DIV |-> ndig_q < 4'(DigitMax))
    else $error("digit count overran the digit buffer");

endmodule

`default_nettype wire

[src/sitar_queue.sv]
// ----------------------------------------------------------------------------
// sitar_queue: two-entry text queue
// Decouples the converter from the record emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module sitar_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  sitar_pkg::sitar_text_t push_data_i,
  input  logic                   pop_i,
  output sitar_pkg::sitar_qstat_t stat_o,
  output sitar_pkg::sitar_text_t head_o
);
  import sitar_pkg::*;

  sitar_text_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o       = mem_q[rd_ptr_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into a full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !stat_o.empty)
    else $error("pop from an empty queue");

endmodule

`default_nettype wire

[src/sitar_back.sv]
// ----------------------------------------------------------------------------
// sitar_back: record emitter
// Walks the head text entry one byte per cycle: text, zero pad, CR, LF.
// ----------------------------------------------------------------------------
`default_nettype none

module sitar_back #(
  parameter int unsigned DIGIT_SLOTS = 21
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic [4:0]              record_length_i,
  input  sitar_pkg::sitar_qstat_t qstat_i,
  input  sitar_pkg::sitar_text_t  head_i,
  output logic                    pop_o,
  output logic [7:0]              out_byte_o,
  output logic                    last_o,
  output logic                    strobe_o
);
  import sitar_pkg::*;

  logic [4:0] pos_q, pos_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       strobe_q, strobe_d;
  logic [4:0] len_c, body;
  logic [4:0] k, didx;
  logic       active, in_slots;

  always_comb begin
    if (record_length_i < LenMin) begin
      len_c = LenMin;
    end else if (record_length_i > LenMax) begin
      len_c = LenMax;
    end else begin
      len_c = record_length_i;
    end
  end

  assign body     = len_c - 5'd2;
  assign active   = !qstat_i.empty;
  assign in_slots = ({1'b0, pos_q} < 6'(DIGIT_SLOTS));
  assign k        = pos_q - {4'd0, head_i.neg};
  assign didx     = {1'b0, head_i.ndig} - 5'd1 - k;

  always_comb begin
    pos_d    = pos_q;
    byte_d   = 8'd0;
    last_d   = 1'b0;
    strobe_d = 1'b0;
    pop_o    = 1'b0;
    if (active) begin
      strobe_d = 1'b1;
      if (pos_q < body) begin
        pos_d = pos_q + 5'd1;
        if (in_slots) begin
          if (head_i.neg && (pos_q == 5'd0)) begin
            byte_d = ChMinus;
          end else if (k < {1'b0, head_i.ndig}) begin
            byte_d = ChZero + {4'd0, head_i.dig[didx[3:0]]};
          end
        end
      end else if (pos_q == body) begin
        pos_d  = pos_q + 5'd1;
        byte_d = ChCr;
      end else begin
        pos_d  = 5'd0;
        byte_d = ChLf;
        last_d = 1'b1;
        pop_o  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q    <= 5'd0;
      last_q   <= 1'b0;
      strobe_q <= 1'b0;
    end else begin
      pos_q    <= pos_d;
      last_q   <= last_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  assign out_byte_o = byte_q;
  assign last_o     = last_q;
  assign strobe_o   = strobe_q;

  a_last_strobed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_q |-> strobe_q)
    else $error("last flagged without a strobe");

  a_pop_on_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> last_q && strobe_q && (byte_q == ChLf))
    else $error("entry dropped without a line feed");

endmodule

`default_nettype wire
